@@ rtl/ewadb_pkg.sv @@
// shared types, constants and helpers for the echo width average distance bands block
package ewadb_pkg;

  localparam int SampleW = 16;
  localparam int CodeW   = 3;
  localparam int CmW     = 8;
  localparam int LimitW  = 14;
  localparam int CfgIdxW = 2;
  localparam int FixedBands = 7;

  localparam logic [5:0] UsPerCm = 6'd58;

  // fixed option b limits in us, largest first
  localparam logic [LimitW-1:0] FixedLimits [FixedBands] = '{
    14'd2320, 14'd2030, 14'd1740, 14'd1450, 14'd1160, 14'd870, 14'd580
  };

  localparam logic [CodeW-1:0] CodeOuter  = 3'd4;
  localparam logic [CodeW-1:0] CodeMiddle = 3'd6;
  localparam logic [CodeW-1:0] CodeInner  = 3'd7;
  localparam logic [CodeW-1:0] CodeNone   = 3'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BAND_MODE = 2'd0,
    REG_OUTER     = 2'd1,
    REG_MIDDLE    = 2'd2,
    REG_INNER     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              band_mode;
    logic [LimitW-1:0] outer_lim;
    logic [LimitW-1:0] middle_lim;
    logic [LimitW-1:0] inner_lim;
  } band_cfg_t;

  function automatic logic [LimitW-1:0] cm_to_us(input logic [CmW-1:0] cm);
    cm_to_us = LimitW'(cm) * LimitW'(UsPerCm);
  endfunction

endpackage

@@ rtl/echo_width_average_distance_bands.sv @@
// top level: moving average of echo widths and distance band classification
// Each beat on the input stream carries one echo width in microseconds and
// produces exactly one output beat with the distance code and the window
// average, in order. The last WINDOW_LENGTH widths sit in a row of cells that
// shift one place per accepted beat (all zero after reset, so early averages
// include the zero padding), and a running sum subtracts the cell that falls
// off the end and adds the new sample. The average is the truncated quotient
// of that sum by WINDOW_LENGTH, done as a registered reciprocal multiply.
// One beat is taken every clock cycle unless the whole pipeline holds, which it
// does while an output beat is waiting and tready is low; each beat passes
// through the registered sum, multiply and classify-into-output stages. Band mode 1
// compares the average with three limits given in cm (scaled by 58 us/cm when
// written); band mode 0 uses seven fixed limits 5 cm apart from 10 to 40 cm
// (eight bands). The user must write configuration through the plain write
// port only while no beat is in flight; the block itself does not enforce it.
module echo_width_average_distance_bands #(
  parameter int WINDOW_LENGTH = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] echo_width_us
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] distance_code, [18:3] filtered_width_us
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int SampleW = ewadb_pkg::SampleW;
  localparam int SumW    = SampleW + $clog2(WINDOW_LENGTH);

  // pipeline control
  logic advance;
  logic accept;
  logic v1_q;
  logic v2_q;
  logic out_v_q;

  assign advance       = !out_v_q || m_axis_tready;
  assign accept        = s_axis_tvalid && advance;
  assign s_axis_tready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (advance) begin
      v1_q    <= accept;
      v2_q    <= v1_q;
      out_v_q <= v2_q;
    end
  end

  // configuration registers, limits kept already scaled to us
  ewadb_pkg::band_cfg_t cfg_q;
  ewadb_pkg::band_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ewadb_pkg::cfg_reg_e'(cfg_index_i))
        ewadb_pkg::REG_BAND_MODE: cfg_d.band_mode  = cfg_wdata_i[0];
        ewadb_pkg::REG_OUTER:     cfg_d.outer_lim  = ewadb_pkg::cm_to_us(cfg_wdata_i);
        ewadb_pkg::REG_MIDDLE:    cfg_d.middle_lim = ewadb_pkg::cm_to_us(cfg_wdata_i);
        ewadb_pkg::REG_INNER:     cfg_d.inner_lim  = ewadb_pkg::cm_to_us(cfg_wdata_i);
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_mode  <= 1'b1;
      cfg_q.outer_lim  <= ewadb_pkg::cm_to_us(8'd20);
      cfg_q.middle_lim <= ewadb_pkg::cm_to_us(8'd15);
      cfg_q.inner_lim  <= ewadb_pkg::cm_to_us(8'd10);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // window: chain of cells, newest at cell 0
  logic [SampleW-1:0] cell_q [WINDOW_LENGTH];

  for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      ewadb_cell u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .en_i  (accept),
        .d_i   (s_axis_tdata[SampleW-1:0]),
        .q_o   (cell_q[k])
      );
    end else begin : g_body
      ewadb_cell u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .en_i  (accept),
        .d_i   (cell_q[k-1]),
        .q_o   (cell_q[k])
      );
    end
  end

  // running sum: drop the oldest, add the newest
  logic [SumW-1:0] sum_q;
  logic [SumW-1:0] sum_d;

  always_comb begin
    sum_d = sum_q;
    if (accept) begin
      sum_d = sum_q - SumW'(cell_q[WINDOW_LENGTH-1]) + SumW'(s_axis_tdata[SampleW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // average
  logic [SampleW-1:0] avg;

  ewadb_div #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_div (
    .clk_i(clk_i),
    .en_i (advance && v1_q),
    .sum_i(sum_q),
    .avg_o(avg)
  );

  // classification into the output register
  logic [ewadb_pkg::CodeW-1:0] code;
  logic [ewadb_pkg::CodeW-1:0] code_q;
  logic [SampleW-1:0]          width_q;

  ewadb_classify u_classify (
    .cfg_i (cfg_q),
    .avg_i (avg),
    .code_o(code)
  );

  always_ff @(posedge clk_i) begin
    if (advance && v2_q) begin
      code_q  <= code;
      width_q <= avg;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, width_q, code_q};

endmodule

@@ rtl/ewadb_cell.sv @@
// one window cell: holds a sample and hands it to the next cell on each beat
module ewadb_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [ewadb_pkg::SampleW-1:0]  d_i,
  output logic [ewadb_pkg::SampleW-1:0]  q_o
);

  logic [ewadb_pkg::SampleW-1:0] data_q;
  logic [ewadb_pkg::SampleW-1:0] data_d;

  always_comb begin
    data_d = en_i ? d_i : data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign q_o = data_q;

endmodule

@@ rtl/ewadb_div.sv @@
// divide the window sum by the window length through a registered reciprocal multiply
module ewadb_div #(
  parameter int WINDOW_LENGTH = 10
) (
  input  logic                                                    clk_i,
  input  logic                                                    en_i,
  input  logic [ewadb_pkg::SampleW+$clog2(WINDOW_LENGTH)-1:0]     sum_i,
  output logic [ewadb_pkg::SampleW-1:0]                           avg_o
);

  localparam int SumW  = ewadb_pkg::SampleW + $clog2(WINDOW_LENGTH);
  localparam int Shift = SumW + $clog2(WINDOW_LENGTH);
  localparam int ProdW = 2 * SumW + 1;
  // ceil(2^Shift / length) gives an exact floor for every sum below 2^SumW
  localparam logic [SumW:0] Recip = (SumW + 1)'(
    ((64'd1 << Shift) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

  logic [ProdW-1:0] prod_q;
  logic [ProdW-1:0] prod_d;

  always_comb begin
    prod_d = en_i ? (ProdW'(sum_i) * ProdW'(Recip)) : prod_q;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign avg_o = prod_q[Shift +: ewadb_pkg::SampleW];

endmodule

@@ rtl/ewadb_classify.sv @@
// map an averaged echo width to the 3-bit distance code
module ewadb_classify (
  input  ewadb_pkg::band_cfg_t              cfg_i,
  input  logic [ewadb_pkg::SampleW-1:0]     avg_i,
  output logic [ewadb_pkg::CodeW-1:0]       code_o
);

  logic [ewadb_pkg::CodeW-1:0] three_code;
  logic [ewadb_pkg::CodeW-1:0] eight_code;
  logic below_o;
  logic below_m;
  logic below_i;

  always_comb begin
    below_o = avg_i < ewadb_pkg::SampleW'(cfg_i.outer_lim);
    below_m = avg_i < ewadb_pkg::SampleW'(cfg_i.middle_lim);
    below_i = avg_i < ewadb_pkg::SampleW'(cfg_i.inner_lim);
    // tested in priority order, so misordered limits fall through as given
    if (below_o && !below_m) begin
      three_code = ewadb_pkg::CodeOuter;
    end else if (below_m && !below_i) begin
      three_code = ewadb_pkg::CodeMiddle;
    end else if (below_i) begin
      three_code = ewadb_pkg::CodeInner;
    end else begin
      three_code = ewadb_pkg::CodeNone;
    end
  end

  // count of fixed limits above the average
  always_comb begin
    eight_code = '0;
    for (int k = 0; k < ewadb_pkg::FixedBands; k++) begin
      if (avg_i < ewadb_pkg::SampleW'(ewadb_pkg::FixedLimits[k])) begin
        eight_code = eight_code + ewadb_pkg::CodeW'(1);
      end
    end
  end

  assign code_o = cfg_i.band_mode ? three_code : eight_code;

endmodule

@@ verif/tb_echo_width_average_distance_bands.sv @@
// self-checking stream testbench for the echo width average distance bands block
module tb_echo_width_average_distance_bands;

  localparam int WinLen     = 10;
  localparam int PipeDepth  = 3;     // pipeline depth from input beat to output beat
  localparam int PhaseBeats = 300;   // random beats per configuration phase
  localparam int NumPhases  = 6;
  localparam int LongHold   = 400;   // one long receiver stall, in cycles
  localparam int IdleLimit  = 2000;  // cycles with no beat on either side before giving up
  localparam int NumRows    = 29;

  // one output beat as it sits in tdata[18:0]
  typedef struct packed {
    logic [15:0] avg_us;
    logic [2:0]  code;
  } band_result_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

  // directed script: a beat with its width, or a register write with its value
  typedef struct packed {
    row_kind_e           kind;
    ewadb_pkg::cfg_reg_e reg_sel;
    logic [15:0]         value;
    logic                typed;   // expected result given in the row itself
    band_result_t        want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] echo_width_us
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [2:0] distance_code, [18:3] filtered_width_us
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_wdata_i;

  // predictor state: sample window, running sum and the band registers
  logic [15:0]  echo_hist [WinLen];
  int unsigned  hist_sum;
  logic         band_sel;
  logic [7:0]   outer_cm;
  logic [7:0]   middle_cm;
  logic [7:0]   inner_cm;

  band_result_t pending_bands [$];
  int           mismatches  = 0;
  int           beats_sent  = 0;
  int           burst_left  = 0;
  int           idle_cycles = 0;
  bit           hold_off_req = 1'b0;

  // directed part: extremes and alternating bit patterns on the width, both band modes,
  // zero limits, all limits at the top, misordered limits
  script_row_t script [NumRows] = '{
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'd0,     1'b1,
      '{16'd0, ewadb_pkg::CodeInner}},                               // empty window
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'hFFFF,  1'b1,
      '{16'd6553, ewadb_pkg::CodeNone}},                             // one max sample / 10
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'hFFFF,  1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'h5555,  1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'hAAAA,  1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'h0001,  1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'hFFFE,  1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'h8000,  1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'h7FFF,  1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'd12345, 1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'hFFFF,  1'b0, '0},   // first sample falls out
    '{ROW_WRITE, ewadb_pkg::REG_BAND_MODE, 16'd0,     1'b0, '0},   // fixed eight bands
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'd0,     1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'd0,     1'b0, '0},
    '{ROW_WRITE, ewadb_pkg::REG_OUTER,     16'd0,     1'b0, '0},   // all limits zero
    '{ROW_WRITE, ewadb_pkg::REG_MIDDLE,    16'd0,     1'b0, '0},
    '{ROW_WRITE, ewadb_pkg::REG_INNER,     16'd0,     1'b0, '0},
    '{ROW_WRITE, ewadb_pkg::REG_BAND_MODE, 16'd1,     1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'hFFFF,  1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'd0,     1'b0, '0},
    '{ROW_WRITE, ewadb_pkg::REG_OUTER,     16'd255,   1'b0, '0},   // all limits at the top
    '{ROW_WRITE, ewadb_pkg::REG_MIDDLE,    16'd255,   1'b0, '0},
    '{ROW_WRITE, ewadb_pkg::REG_INNER,     16'd255,   1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'd0,     1'b0, '0},
    '{ROW_WRITE, ewadb_pkg::REG_OUTER,     16'd10,    1'b0, '0},   // outer below inner below middle
    '{ROW_WRITE, ewadb_pkg::REG_MIDDLE,    16'd20,    1'b0, '0},
    '{ROW_WRITE, ewadb_pkg::REG_INNER,     16'd15,    1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'd1000,  1'b0, '0},
    '{ROW_BEAT,  ewadb_pkg::REG_BAND_MODE, 16'd0,     1'b0, '0}
  };

  echo_width_average_distance_bands #(
    .WINDOW_LENGTH(WinLen)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // fixed band limit k in us: 40, 35, ... 10 cm
  function automatic int unsigned fixed_edge(input int k);
    return (40 - 5 * k) * int'(ewadb_pkg::UsPerCm);
  endfunction

  // offer one width at a falling edge, wait for the beat, predict, then pace the sender
  task automatic offer_width(input logic [15:0] w, input bit typed = 1'b0,
                             input band_result_t typed_res = '0);
    band_result_t want;
    int unsigned  avg;
    int unsigned  lim_o;
    int unsigned  lim_m;
    int unsigned  lim_i;
    int           k;
    int           gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // oldest sample drops out of the sum, newest goes in
    hist_sum = hist_sum - echo_hist[WinLen-1] + w;
    for (k = WinLen - 1; k > 0; k--) echo_hist[k] = echo_hist[k-1];
    echo_hist[0] = w;
    avg = hist_sum / WinLen;
    want.avg_us = 16'(avg);
    if (band_sel) begin
      // three bands, tested outer first; misordered limits are taken as they are
      lim_o = int'(outer_cm) * int'(ewadb_pkg::UsPerCm);
      lim_m = int'(middle_cm) * int'(ewadb_pkg::UsPerCm);
      lim_i = int'(inner_cm) * int'(ewadb_pkg::UsPerCm);
      if (avg < lim_o && avg >= lim_m) want.code = ewadb_pkg::CodeOuter;
      else if (avg < lim_m && avg >= lim_i) want.code = ewadb_pkg::CodeMiddle;
      else if (avg < lim_i) want.code = ewadb_pkg::CodeInner;
      else want.code = ewadb_pkg::CodeNone;
    end else begin
      // count of fixed limits above the average
      want.code = '0;
      for (k = 0; k < ewadb_pkg::FixedBands; k++)
        if (avg < fixed_edge(k)) want.code = want.code + 3'd1;
    end
    pending_bands.push_back(typed ? typed_res : want);
    beats_sent++;
    @(negedge clk_i);
    // bursts of random length, random gaps between them, some gaps empty
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // stop offering and wait for every expected beat, plus the pipeline depth
  task automatic drain_pending();
    s_axis_tvalid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    repeat (PipeDepth) @(negedge clk_i);
  endtask

  // one register write, only called with nothing in flight
  task automatic write_reg(input ewadb_pkg::cfg_reg_e sel, input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= v;
    case (sel)
      ewadb_pkg::REG_BAND_MODE: band_sel  = v[0];
      ewadb_pkg::REG_OUTER:     outer_cm  = v;
      ewadb_pkg::REG_MIDDLE:    middle_cm = v;
      ewadb_pkg::REG_INNER:     inner_cm  = v;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // all four registers; upper bits of the mode write are junk that must be ignored
  task automatic program_bands(input logic mode, input logic [7:0] o, input logic [7:0] m,
                               input logic [7:0] i);
    write_reg(ewadb_pkg::REG_BAND_MODE, {7'($urandom), mode});
    write_reg(ewadb_pkg::REG_OUTER, o);
    write_reg(ewadb_pkg::REG_MIDDLE, m);
    write_reg(ewadb_pkg::REG_INNER, i);
  endtask

  // receiver: regimes of random length, plus one long stall on request
  initial begin : rx_pacing
    int         regime;
    int         span;
    int         idx;
    logic [7:0] mask;
    m_axis_tready = 1'b0;
    idx  = 0;
    mask = 8'hFF;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        // long stall so the pipeline fills and backs up into the input
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      regime = $urandom_range(0, 3);
      span   = $urandom_range(8, 64);
      mask   = 8'($urandom) | 8'h01;
      repeat (span) begin
        @(negedge clk_i);
        case (regime)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: begin
            m_axis_tready <= mask[idx];
            idx = (idx + 1) % 8;
          end
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // output side: every beat against the oldest expectation
  always @(posedge clk_i) begin
    band_result_t got;
    band_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[18:0];
      if (pending_bands.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output beat: expected none, actual code %0d avg %0d",
                 $time, got.code, got.avg_us);
      end else begin
        want = pending_bands.pop_front();
        if (got.code !== want.code) begin
          mismatches++;
          $display("%0t: distance_code mismatch: expected %0d, actual %0d",
                   $time, want.code, got.code);
        end
        if (got.avg_us !== want.avg_us) begin
          mismatches++;
          $display("%0t: filtered_width_us mismatch: expected %0d, actual %0d",
                   $time, want.avg_us, got.avg_us);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_echo_width_average_distance_bands: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int   r;
    int   k;
    int   ph;
    int   kind;
    int   run_len;
    int   level;
    int   beat_goal;
    bit   hold_asked;
    bit   pause_done;
    logic [7:0] a;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = ewadb_pkg::REG_BAND_MODE;
    cfg_wdata_i   = '0;
    // predictor state after reset
    for (k = 0; k < WinLen; k++) echo_hist[k] = '0;
    hist_sum   = 0;
    band_sel   = 1'b1;
    outer_cm   = 8'd20;
    middle_cm  = 8'd15;
    inner_cm   = 8'd10;
    hold_asked = 1'b0;
    pause_done = 1'b0;
    beat_goal  = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed script
    for (r = 0; r < NumRows; r++) begin
      if (script[r].kind == ROW_WRITE) begin
        drain_pending();
        write_reg(script[r].reg_sel, script[r].value[7:0]);
      end else begin
        offer_width(script[r].value, script[r].typed, script[r].want);
      end
    end

    // random phases, each under its own band setting
    for (ph = 0; ph < NumPhases; ph++) begin
      drain_pending();
      case (ph)
        0: program_bands(1'b0, 8'd20, 8'd15, 8'd10);
        1: program_bands(1'b1, 8'd20, 8'd15, 8'd10);
        2: program_bands(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        3: program_bands(1'b1, 8'd255, 8'd0, 8'd0);
        4: begin
          // inner above middle above outer
          a = 8'($urandom_range(0, 80));
          program_bands(1'b1, a, a + 8'($urandom_range(1, 80)), a + 8'($urandom_range(81, 170)));
        end
        default: program_bands(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      beat_goal += PhaseBeats;
      while (beats_sent < beat_goal) begin
        if (ph == 2 && !hold_asked && beats_sent >= beat_goal - PhaseBeats / 2) begin
          hold_off_req = 1'b1;
          hold_asked   = 1'b1;
        end
        if (ph == NumPhases - 1 && !pause_done && beats_sent >= beat_goal - PhaseBeats / 2) begin
          // sender waits for every outstanding result mid-phase
          drain_pending();
          pause_done = 1'b1;
        end
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
          // plateau right at an active limit, long enough to fill the window
          if (band_sel) begin
            case ($urandom_range(0, 2))
              0:       level = int'(outer_cm) * int'(ewadb_pkg::UsPerCm);
              1:       level = int'(middle_cm) * int'(ewadb_pkg::UsPerCm);
              default: level = int'(inner_cm) * int'(ewadb_pkg::UsPerCm);
            endcase
          end else begin
            level = int'(fixed_edge($urandom_range(0, ewadb_pkg::FixedBands - 1)));
          end
          level = level + int'($urandom_range(0, 2)) - 1;
          if (level < 0) level = 0;
          if (level > 65535) level = 65535;
          run_len = $urandom_range(10, 16);
          repeat (run_len) offer_width(16'(level));
        end else if (kind <= 5) begin
          // short distances, around the band limits
          repeat ($urandom_range(1, 20)) offer_width(16'($urandom_range(0, 3000)));
        end else if (kind <= 7) begin
          repeat ($urandom_range(1, 20)) offer_width(16'($urandom));
        end else if (kind == 8) begin
          repeat ($urandom_range(1, 12))
            offer_width(($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000);
        end else begin
          level = $urandom_range(0, 65535);
          repeat ($urandom_range(10, 14)) offer_width(16'(level));
        end
      end
    end

    drain_pending();
    repeat (PipeDepth + 5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_echo_width_average_distance_bands: done, clean");
    end else begin
      $display("tb_echo_width_average_distance_bands: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ewadb_pkg.sv
rtl/ewadb_cell.sv
rtl/ewadb_div.sv
rtl/ewadb_classify.sv
rtl/echo_width_average_distance_bands.sv
verif/tb_echo_width_average_distance_bands.sv
